### sv/plc_pkg.sv
// Shared types and constants of the packet layer classifier.
// Depends on nothing; the datapath, controller and top-level files of the block import it.
package plc_pkg;

	localparam int BUF_BYTES_DEF = 128;
	// Bytes at the head of the packet that the classifier inspects directly.
	localparam int HDR_BYTES = 28;

	localparam int FL_ETH  = 0;
	localparam int FL_VLAN = 1;
	localparam int FL_IPV4 = 2;
	localparam int FL_IPV6 = 3;
	localparam int FL_TCP  = 4;

	localparam logic [15:0] ET_IPV4 = 16'h0800;
	localparam logic [15:0] ET_IPV6 = 16'h86DD;
	localparam logic [15:0] ET_VLAN = 16'h8100;
	localparam logic [7:0]  PROTO_TCP = 8'd6;

	typedef struct packed {
		logic load;
		logic calc;
		logic finish;
		logic clear;
	} cmd_t;

	// Ones'-complement fold of a wide sum; true when the header checksums to all ones.
	function automatic logic csum_ok(input logic [20:0] s);
		logic [16:0] f;
		logic [16:0] g;
		f = {12'd0, s[20:16]} + {1'b0, s[15:0]};
		g = {1'b0, f[15:0]} + {16'd0, f[16]};
		return g[15:0] == 16'hFFFF;
	endfunction

	function automatic logic v6_listed(input logic [7:0] nh);
		return nh == 8'd6 || nh == 8'd17 || nh == 8'd41 || nh == 8'd43 ||
			nh == 8'd44 || nh == 8'd58 || nh == 8'd59 || nh == 8'd60;
	endfunction

endpackage

### sv/plc_if.sv
// Stream interfaces of the packet layer classifier: byte input and result output.
// Depends on nothing.
interface plc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pkt_byte;
	logic       last_byte;
	modport source (output valid, pkt_byte, last_byte, input ready);
	modport sink (input valid, pkt_byte, last_byte, output ready);
endinterface

interface plc_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] layer_flags;
	logic [4:0] link_len;
	logic [4:0] net_offset;
	logic [5:0] net_len;
	logic [6:0] tcp_offset;
	logic [5:0] tcp_len;
	modport source (output valid, layer_flags, link_len, net_offset, net_len, tcp_offset,
		tcp_len, input ready);
	modport sink (input valid, layer_flags, link_len, net_offset, net_len, tcp_offset,
		tcp_len, output ready);
endinterface

### sv/plc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module plc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

### sv/plc_datapath.sv
// Datapath: byte counter, header capture, running checksums, decision and result registers.
// Depends on plc_pkg and plc_ram.
module plc_datapath #(
	parameter int BUF_BYTES = plc_pkg::BUF_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  plc_pkg::cmd_t cmd,
	input  logic [7:0]   pkt_byte,
	output logic [4:0]   layer_flags,
	output logic [4:0]   link_len,
	output logic [4:0]   net_offset,
	output logic [5:0]   net_len,
	output logic [6:0]   tcp_offset,
	output logic [5:0]   tcp_len
);
	import plc_pkg::*;

	localparam int AW = $clog2(BUF_BYTES);
	localparam int CW = $clog2(BUF_BYTES + 1);
	localparam int HW = $clog2(HDR_BYTES);
	localparam logic [CW-1:0] BASE [3] = '{CW'(0), CW'(14), CW'(18)};

	logic [CW-1:0] cnt_q;
	logic [7:0]    hb_q [HDR_BYTES];
	logic [20:0]   sum_q [3];
	logic [20:0]   sum_d [3];
	logic          wr_en;

	logic [4:0] flags_q, flags_d;
	logic [4:0] link_q, link_d;
	logic [4:0] noff_q, noff_d;
	logic [5:0] nlen_q, nlen_d;
	logic [6:0] toff_q, toff_d;
	logic [5:0] tlen_q;
	logic [7:0] ram_rdata;
	logic [7:0] taddr;

	assign wr_en = cmd.load && (cnt_q < CW'(BUF_BYTES));
	assign taddr = {1'b0, toff_q} + 8'd12;

	plc_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_buf (
		.clk   (clk),
		.we    (wr_en),
		.waddr (cnt_q[AW-1:0]),
		.wdata (pkt_byte),
		.raddr (AW'(taddr)),
		.rdata (ram_rdata)
	);

	// Each candidate header base keeps its own sum; a byte counts when it lies inside the
	// header span, which the IHL nibble at that base fixes before later bytes arrive.
	always_comb begin
		logic [CW-1:0] rel;
		logic [3:0]    ihl;
		logic [5:0]    lim;
		for (int l = 0; l < 3; l++) begin
			rel = cnt_q - BASE[l];
			ihl = (cnt_q == BASE[l]) ? pkt_byte[3:0] : hb_q[BASE[l][HW-1:0]][3:0];
			lim = (ihl >= 4'd6) ? {ihl, 2'b00} : 6'd20;
			sum_d[l] = sum_q[l];
			if (cnt_q >= BASE[l] && rel < CW'(lim)) begin
				sum_d[l] = sum_q[l] + (rel[0] ? {13'd0, pkt_byte} : {5'd0, pkt_byte, 8'd0});
			end
		end
	end

	always_comb begin
		logic [15:0] et1, et2;
		logic [5:0]  h0, h14, h18;
		logic        done;
		et1 = {hb_q[12], hb_q[13]};
		et2 = {hb_q[16], hb_q[17]};
		h0  = {hb_q[0][3:0], 2'b00};
		h14 = {hb_q[14][3:0], 2'b00};
		h18 = {hb_q[18][3:0], 2'b00};
		flags_d = '0;
		link_d  = '0;
		noff_d  = '0;
		nlen_d  = '0;
		toff_d  = '0;
		done    = 1'b1;
		if (hb_q[0][7:4] == 4'd4 && csum_ok(sum_q[0])) begin
			flags_d[FL_IPV4] = 1'b1;
			nlen_d = h0;
			if (hb_q[9] == PROTO_TCP) begin
				flags_d[FL_TCP] = 1'b1;
				toff_d = {1'b0, h0};
			end
		end else begin
			flags_d[FL_ETH] = 1'b1;
			link_d = 5'd14;
			priority if (et1 == ET_IPV4 && csum_ok(sum_q[1])) begin
				flags_d[FL_IPV4] = 1'b1;
				noff_d = 5'd14;
				nlen_d = h14;
				if (hb_q[23] == PROTO_TCP) begin
					flags_d[FL_TCP] = 1'b1;
					toff_d = 7'd14 + {1'b0, h14};
				end
			end else if (et1 == ET_IPV6 && hb_q[14][7:4] == 4'd6) begin
				flags_d[FL_IPV6] = 1'b1;
				noff_d = 5'd14;
				nlen_d = 6'd40;
				if (hb_q[20] == PROTO_TCP) begin
					flags_d[FL_TCP] = 1'b1;
					toff_d = 7'd54;
				end
			end else if (et1 == ET_VLAN) begin
				flags_d = '0;
				flags_d[FL_VLAN] = 1'b1;
				link_d = 5'd18;
				priority if (et2 == ET_IPV4 && csum_ok(sum_q[2])) begin
					flags_d[FL_IPV4] = 1'b1;
					noff_d = 5'd18;
					nlen_d = h18;
					if (hb_q[27] == PROTO_TCP) begin
						flags_d[FL_TCP] = 1'b1;
						toff_d = 7'd18 + {1'b0, h18};
					end
				end else if (et2 == ET_IPV6 && hb_q[18][7:4] == 4'd6) begin
					flags_d[FL_IPV6] = 1'b1;
					noff_d = 5'd18;
					nlen_d = 6'd40;
					if (hb_q[24] == PROTO_TCP) begin
						flags_d[FL_TCP] = 1'b1;
						toff_d = 7'd58;
					end
				end else begin
					done = 1'b0;
				end
			end else begin
				done = 1'b0;
			end
		end
		if (!done && hb_q[0][7:4] == 4'd6 && v6_listed(hb_q[6])) begin
			flags_d = '0;
			flags_d[FL_IPV6] = 1'b1;
			link_d = '0;
			noff_d = '0;
			nlen_d = 6'd40;
			toff_d = '0;
			if (hb_q[6] == PROTO_TCP) begin
				flags_d[FL_TCP] = 1'b1;
				toff_d = 7'd40;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < HDR_BYTES; i++) begin
				hb_q[i] <= '0;
			end
			for (int l = 0; l < 3; l++) begin
				sum_q[l] <= '0;
			end
		end else if (cmd.clear) begin
			cnt_q <= '0;
			for (int i = 0; i < HDR_BYTES; i++) begin
				hb_q[i] <= '0;
			end
			for (int l = 0; l < 3; l++) begin
				sum_q[l] <= '0;
			end
		end else if (wr_en) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q < CW'(HDR_BYTES)) begin
				hb_q[cnt_q[HW-1:0]] <= pkt_byte;
			end
			for (int l = 0; l < 3; l++) begin
				sum_q[l] <= sum_d[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			flags_q <= flags_d;
			link_q  <= link_d;
			noff_q  <= noff_d;
			nlen_q  <= nlen_d;
			toff_q  <= toff_d;
		end
		if (cmd.finish) begin
			if (flags_q[FL_TCP] && {1'b0, taddr} < 9'(cnt_q)) begin
				tlen_q <= {ram_rdata[7:4], 2'b00};
			end else begin
				tlen_q <= '0;
			end
		end
	end

	assign layer_flags = flags_q;
	assign link_len    = link_q;
	assign net_offset  = noff_q;
	assign net_len     = nlen_q;
	assign tcp_offset  = toff_q;
	assign tcp_len     = tlen_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(BUF_BYTES))
		else $error("byte count ran past the buffer");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> cnt_q == '0)
		else $error("byte count not cleared after result");
endmodule

### sv/plc_ctrl.sv
// Controller state machine: sequences load, decision, buffer read and result delivery.
// Depends on plc_pkg.
module plc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output plc_pkg::cmd_t cmd
);
	import plc_pkg::*;

	typedef enum logic [2:0] {S_LOAD, S_CALC, S_FETCH, S_FINISH, S_SEND} state_t;
	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_valid && in_last) begin
						state_q <= S_CALC;
					end
				end
				S_CALC:   state_q <= S_FETCH;
				S_FETCH:  state_q <= S_FINISH;
				S_FINISH: state_q <= S_SEND;
				S_SEND: begin
					if (out_ready) begin
						state_q <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign in_ready   = (state_q == S_LOAD);
	assign out_valid  = (state_q == S_SEND);
	assign cmd.load   = in_ready && in_valid;
	assign cmd.calc   = (state_q == S_CALC);
	assign cmd.finish = (state_q == S_FINISH);
	assign cmd.clear  = out_valid && out_ready;

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc |=> ##1 cmd.finish)
		else $error("decision not followed by buffer read");
endmodule

### sv/packet_layer_classifier_top.sv
// Packet layer classifier: one byte accepted per cycle while loading. After the byte
// marked last, the controller passes through the decision, buffer read and read-data
// states before the result is valid; the next packet is accepted only once the result
// has been taken, so any output stall holds the input as well.
// The tail delay is set by the single read port of the head buffer, needed for the TCP
// data-offset byte. Reset is asynchronous, active low, and clears the byte count, the
// captured header bytes and the checksum sums; buffer contents are not cleared.
module packet_layer_classifier_top #(
	parameter int BUF_BYTES = plc_pkg::BUF_BYTES_DEF
) (
	input logic      clk,
	input logic      arst_n,
	plc_in_if.sink   in_ch,
	plc_out_if.source out_ch
);
	import plc_pkg::*;

	// Commands from the controller to the datapath.
	cmd_t cmd;

	// The controller owns the handshakes; the datapath only sees the byte and commands.
	plc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_last   (in_ch.last_byte),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// Checksums for the three candidate IPv4 positions build up while bytes stream in,
	// so the decision itself is made in the single calc state after the last byte.
	plc_datapath #(.BUF_BYTES(BUF_BYTES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.pkt_byte    (in_ch.pkt_byte),
		.layer_flags (out_ch.layer_flags),
		.link_len    (out_ch.link_len),
		.net_offset  (out_ch.net_offset),
		.net_len     (out_ch.net_len),
		.tcp_offset  (out_ch.tcp_offset),
		.tcp_len     (out_ch.tcp_len)
	);
endmodule

### verif/plc_tb_if.sv
// Testbench-side copies are not needed: the block's own interfaces in sv/plc_if.sv are used.
// This file holds the helper package of the testbench and depends on plc_pkg.
package plc_tb_pkg;
	import plc_pkg::*;

	typedef struct {
		logic [7:0] pkt_byte;
		logic       last_byte;
	} byte_req_t;

	typedef struct {
		logic [4:0] layer_flags;
		logic [4:0] link_len;
		logic [4:0] net_offset;
		logic [5:0] net_len;
		logic [6:0] tcp_offset;
		logic [5:0] tcp_len;
	} layer_res_t;
endpackage

### verif/packet_layer_classifier_top_tb.sv
// Self-checking testbench of packet_layer_classifier_top: packets are streamed byte by byte
// and each classification result is checked against an in-bench layer predictor.
// Depends on plc_pkg, plc_if.sv, plc_tb_pkg and the block's RTL.
module packet_layer_classifier_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import plc_pkg::*;
	import plc_tb_pkg::*;

	localparam int BUF = BUF_BYTES_DEF;
	localparam int LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #6 clk = ~clk;

	plc_in_if in_ch ();
	plc_out_if out_ch ();

	packet_layer_classifier_top dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	// Requests waiting to be driven, and results the predictor expects, oldest first.
	byte_req_t  pending_bytes[$];
	layer_res_t expected_layers[$];
	// Predictor copy of the packet head.
	logic [7:0] pkt_head[BUF];
	int unsigned head_count = 0;
	int errors = 0;
	int packets_sent = 0;
	int results_seen = 0;
	int cycles = 0;
	bit no_idle = 1'b0;
	bit hold_send = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	function automatic int unsigned hb(int unsigned i);
		if (i >= head_count || i >= BUF)
			return 0;
		return pkt_head[i];
	endfunction

	function automatic int unsigned hw(int unsigned i);
		return (hb(i) << 8) | hb(i + 1);
	endfunction

	// Checksum check of an IPv4 header at base; hlen returns IHL times four.
	function automatic bit ipv4_sum_good(int unsigned base, output int unsigned hlen);
		int unsigned words;
		int unsigned sum;
		words = 10;
		sum = 0;
		hlen = (hb(base) & 4'hF) * 4;
		if (hlen >= 24 && hlen <= 60)
			words = hlen / 2;
		for (int k = 0; k < words; k++)
			sum += hw(base + 2 * k);
		sum = (sum >> 16) + (sum & 32'h0000FFFF);
		sum += sum >> 16;
		return ((~sum) & 32'hFFFF) == 0;
	endfunction

	function automatic int unsigned tcp_hdr_len(int unsigned off);
		return (hb(off + 12) >> 4) * 4;
	endfunction

	// Feeds one accepted byte to the layer predictor; on the last byte it queues a result.
	function automatic void classify_byte(byte_req_t b);
		int unsigned flags, link, noff, nlen, toff, tlen, h, et, ver, nh;
		bit found;
		layer_res_t r;
		flags = 0; link = 0; noff = 0; nlen = 0; toff = 0; tlen = 0; found = 0;
		if (head_count < BUF) begin
			pkt_head[head_count] = b.pkt_byte;
			head_count++;
		end
		if (!b.last_byte)
			return;
		ver = hb(0) >> 4;
		if (ver == 4 && ipv4_sum_good(0, h)) begin
			flags = 1 << FL_IPV4; nlen = h; found = 1;
			if (hb(9) == PROTO_TCP) begin
				flags |= 1 << FL_TCP; toff = h; tlen = tcp_hdr_len(h);
			end
		end
		if (!found) begin
			flags = 1 << FL_ETH; link = 14;
			et = hw(12);
			if (et == ET_IPV4 && ipv4_sum_good(14, h)) begin
				flags |= 1 << FL_IPV4; noff = 14; nlen = h; found = 1;
				if (hb(23) == PROTO_TCP) begin
					flags |= 1 << FL_TCP; toff = 14 + h; tlen = tcp_hdr_len(toff);
				end
			end else if (et == ET_IPV6 && (hb(14) >> 4) == 6) begin
				flags |= 1 << FL_IPV6; noff = 14; nlen = 40; found = 1;
				if (hb(20) == PROTO_TCP) begin
					flags |= 1 << FL_TCP; toff = 54; tlen = tcp_hdr_len(54);
				end
			end else if (et == ET_VLAN) begin
				flags = 1 << FL_VLAN; link = 18;
				et = hw(16);
				if (et == ET_IPV4 && ipv4_sum_good(18, h)) begin
					flags |= 1 << FL_IPV4; noff = 18; nlen = h; found = 1;
					if (hb(27) == PROTO_TCP) begin
						flags |= 1 << FL_TCP; toff = 18 + h; tlen = tcp_hdr_len(toff);
					end
				end else if (et == ET_IPV6 && (hb(18) >> 4) == 6) begin
					flags |= 1 << FL_IPV6; noff = 18; nlen = 40; found = 1;
					if (hb(24) == PROTO_TCP) begin
						flags |= 1 << FL_TCP; toff = 58; tlen = tcp_hdr_len(58);
					end
				end
			end
		end
		if (!found && ver == 6) begin
			nh = hb(6);
			if (nh == 6 || nh == 17 || nh == 41 || nh == 43 || nh == 44 || nh == 58 ||
				nh == 59 || nh == 60) begin
				flags = 1 << FL_IPV6; link = 0; noff = 0; nlen = 40;
				if (nh == PROTO_TCP) begin
					flags |= 1 << FL_TCP; toff = 40; tlen = tcp_hdr_len(40);
				end
			end
		end
		r.layer_flags = flags[4:0];
		r.link_len = link[4:0];
		r.net_offset = noff[4:0];
		r.net_len = nlen[5:0];
		r.tcp_offset = toff[6:0];
		r.tcp_len = tlen[5:0];
		expected_layers.push_back(r);
		head_count = 0;
	endfunction

	// Packet construction. A packet is built in a byte array, then queued as requests.
	logic [7:0] pkt[$];

	task automatic queue_packet();
		byte_req_t b;
		if (pkt.size() == 0)
			pkt.push_back(8'($urandom));
		foreach (pkt[i]) begin
			b.pkt_byte = pkt[i];
			b.last_byte = (i == pkt.size() - 1);
			pending_bytes.push_back(b);
		end
		packets_sent++;
	endtask

	// Writes a valid checksum into the IPv4 header at base with header length hl bytes.
	task automatic fix_ipv4_sum(int base, int hl);
		int unsigned sum;
		int words;
		words = (hl >= 24 && hl <= 60) ? hl / 2 : 10;
		pkt[base + 10] = 0;
		pkt[base + 11] = 0;
		sum = 0;
		for (int k = 0; k < words; k++)
			sum += {pkt[base + 2 * k], pkt[base + 2 * k + 1]};
		sum = (sum >> 16) + (sum & 32'hFFFF);
		sum += sum >> 16;
		sum = ~sum;
		pkt[base + 10] = sum[15:8];
		pkt[base + 11] = sum[7:0];
	endtask

	// Builds a packet of one layout. kind: 0 raw IPv4, 1 Ethernet IPv4, 2 Ethernet IPv6,
	// 3 VLAN IPv4, 4 VLAN IPv6, 5 raw IPv6, 6 random noise.
	task automatic build_packet(int kind, int ihl, bit tcp, bit bad_sum, int extra);
		int base;
		int hl;
		int total;
		bit v4;
		base = (kind == 1 || kind == 2) ? 14 : (kind == 3 || kind == 4) ? 18 : 0;
		v4 = (kind == 0 || kind == 1 || kind == 3);
		hl = v4 ? ihl * 4 : 40;
		if (v4 && hl < 20)
			total = base + 20;
		else
			total = base + hl;
		if (tcp)
			total += 20;
		total += extra;
		if (total < 1)
			total = 1;
		pkt.delete();
		for (int i = 0; i < total + 64; i++)
			pkt.push_back(8'($urandom));
		if (kind == 6) begin
			pkt = pkt[0:total - 1];
			return;
		end
		if (base == 14) begin
			{pkt[12], pkt[13]} = v4 ? ET_IPV4 : ET_IPV6;
		end else if (base == 18) begin
			{pkt[12], pkt[13]} = ET_VLAN;
			{pkt[16], pkt[17]} = v4 ? ET_IPV4 : ET_IPV6;
		end
		if (v4) begin
			// The encapsulated version nibble is left random on purpose sometimes.
			pkt[base] = {(base == 0 || $urandom_range(0, 1)) ? 4'd4 : 4'($urandom), 4'(ihl)};
			pkt[base + 9] = tcp ? PROTO_TCP : 8'($urandom_range(7, 255));
		end else begin
			pkt[base] = {4'd6, 4'($urandom)};
			pkt[base + 6] = tcp ? PROTO_TCP :
				8'($urandom_range(0, 1) ? 17 : $urandom_range(0, 255));
		end
		if (tcp)
			pkt[base + (v4 && hl >= 20 ? hl : v4 ? 20 : 40) + 12] = {4'($urandom), 4'($urandom)};
		if (v4)
			fix_ipv4_sum(base, hl);
		if (bad_sum)
			pkt[base + 11] ^= 8'(1 << $urandom_range(0, 7));
		pkt = pkt[0:total - 1];
	endtask

	// Driver: presents queued requests, with random idle bursts unless disabled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.pkt_byte <= '0;
			in_ch.last_byte <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				classify_byte(pending_bytes.pop_front());
			end
			if (in_ch.valid && !in_ch.ready) begin
				// Hold the current request until accepted.
			end else if (send_gap > 0) begin
				in_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_bytes.size() > 0 && !hold_send) begin
				if (!no_idle && $urandom_range(0, 9) == 0) begin
					in_ch.valid <= 1'b0;
					send_gap <= $urandom_range(0, 5);
				end else begin
					in_ch.valid <= 1'b1;
					in_ch.pkt_byte <= pending_bytes[0].pkt_byte;
					in_ch.last_byte <= pending_bytes[0].last_byte;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: accepts results with random stalls and checks each field.
	always @(posedge clk or negedge arst_n) begin
		layer_res_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			cycles <= cycles + 1;
			if (out_ch.valid && out_ch.ready) begin
				results_seen <= results_seen + 1;
				if (expected_layers.size() == 0) begin
					$error("result with no request waiting: flags %0h", out_ch.layer_flags);
					errors++;
				end else begin
					e = expected_layers.pop_front();
					if (out_ch.layer_flags !== e.layer_flags) begin
						$error("layer_flags expected %0h got %0h", e.layer_flags,
							out_ch.layer_flags);
						errors++;
					end
					if (out_ch.link_len !== e.link_len) begin
						$error("link_len expected %0d got %0d", e.link_len, out_ch.link_len);
						errors++;
					end
					if (out_ch.net_offset !== e.net_offset) begin
						$error("net_offset expected %0d got %0d", e.net_offset,
							out_ch.net_offset);
						errors++;
					end
					if (out_ch.net_len !== e.net_len) begin
						$error("net_len expected %0d got %0d", e.net_len, out_ch.net_len);
						errors++;
					end
					if (out_ch.tcp_offset !== e.tcp_offset) begin
						$error("tcp_offset expected %0d got %0d", e.tcp_offset,
							out_ch.tcp_offset);
						errors++;
					end
					if (out_ch.tcp_len !== e.tcp_len) begin
						$error("tcp_len expected %0d got %0d", e.tcp_len, out_ch.tcp_len);
						errors++;
					end
				end
			end
			if (recv_gap > 0) begin
				out_ch.ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 1'b0;
				recv_gap <= $urandom_range(0, 5);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Timeout watchdog.
	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int kind;
		int bytes_queued;
		// Directed part: extremes of the layouts and each special case.
		build_packet(0, 5, 1, 0, 0); queue_packet();      // raw IPv4 with TCP
		build_packet(0, 15, 1, 0, 4); queue_packet();     // longest options
		build_packet(0, 3, 0, 0, 0); queue_packet();      // short IHL
		build_packet(0, 5, 0, 1, 0); queue_packet();      // bad checksum, falls through
		build_packet(1, 6, 1, 0, 0); queue_packet();      // Ethernet IPv4 with options
		build_packet(1, 5, 0, 1, 0); queue_packet();      // Ethernet, bad checksum
		build_packet(2, 0, 1, 0, 0); queue_packet();      // Ethernet IPv6 TCP
		build_packet(3, 5, 1, 0, 0); queue_packet();      // VLAN IPv4 TCP
		build_packet(3, 5, 0, 1, 0); queue_packet();      // VLAN, nothing found
		build_packet(4, 0, 1, 0, 0); queue_packet();      // VLAN IPv6 TCP
		build_packet(5, 0, 1, 0, 0); queue_packet();      // raw IPv6 TCP
		build_packet(5, 0, 0, 0, 0); queue_packet();      // raw IPv6 other header
		build_packet(1, 5, 1, 0, -30); queue_packet();    // truncated, missing bytes read zero
		build_packet(6, 0, 0, 0, 200); queue_packet();    // long packet past the buffer
		pkt.delete(); pkt.push_back(8'h00); queue_packet(); // one zero byte
		pkt.delete(); pkt.push_back(8'hFF); queue_packet(); // one all-ones byte
		#1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		bytes_queued = 0;
		foreach (pending_bytes[i])
			bytes_queued++;
		// Pause the sender until every expected result has come back.
		wait (pending_bytes.size() == 0);
		@(posedge clk);
		hold_send = 1'b1;
		for (int p = 0; p < 6; p++) begin
			kind = $urandom_range(0, 9);
			if (kind > 6)
				kind = $urandom_range(0, 5);
			build_packet(kind, $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) :
				$urandom_range(5, 15), $urandom_range(0, 2) != 0, $urandom_range(0, 7) == 0,
				$urandom_range(0, 9) == 0 ? -int'($urandom_range(1, 40)) :
				$urandom_range(0, 12));
			bytes_queued += pkt.size();
			queue_packet();
		end
		wait (expected_layers.size() == 0);
		@(posedge clk);
		hold_send = 1'b0;
		// Random part, mostly well-formed headers with random content.
		while (bytes_queued < 1650) begin
			wait (pending_bytes.size() < 200);
			kind = $urandom_range(0, 9);
			if (kind > 6)
				kind = $urandom_range(0, 5);
			build_packet(kind, $urandom_range(0, 9) == 0 ? $urandom_range(0, 15) :
				$urandom_range(5, 15), $urandom_range(0, 2) != 0, $urandom_range(0, 7) == 0,
				$urandom_range(0, 9) == 0 ? -int'($urandom_range(1, 40)) :
				$urandom_range(0, 8));
			bytes_queued += pkt.size();
			if (bytes_queued > 1350)
				no_idle = 1'b1;
			queue_packet();
		end
		wait (pending_bytes.size() == 0);
		wait (expected_layers.size() == 0);
		repeat (20) @(posedge clk);
		$display("Sent %0d packets; checked %0d classification results across all layouts.",
			packets_sent, results_seen);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
